// File: src/cvs_pkg.sv
// Shared types, codes and constants of the cache victim selector.
package cvs_pkg;

	localparam int ENTRIES_DEFAULT = 16;

	localparam int OP_W     = 3;
	localparam int IDX_W    = 4;
	localparam int LEN_W    = 16;
	localparam int HIT_W    = 8;
	localparam int STATUS_W = 2;
	localparam int COUNT_W  = 5;
	localparam int MAXL_W   = 5;
	localparam int CFG_W    = 5;

	localparam int S_TDATA_W = 24;
	localparam int M_TDATA_W = 16;

	localparam logic [HIT_W-1:0]  HIT_LIMIT    = 8'd100;
	localparam logic [HIT_W-1:0]  HIT_MAX      = 8'hFF;
	localparam logic [MAXL_W-1:0] MAXL_RESET   = 5'd16;

	// register indexes of the configuration port
	localparam logic CFG_MAX_LOADED  = 1'b0;
	localparam logic CFG_STATIC_MODE = 1'b1;

	typedef enum logic [OP_W-1:0] {
		OP_TOUCH   = 3'd0,
		OP_DIRTY   = 3'd1,
		OP_CLEAN   = 3'd2,
		OP_LOAD    = 3'd3,
		OP_RELEASE = 3'd4,
		OP_FIND    = 3'd5
	} cvs_op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_DONE    = 2'd0,
		ST_EVICT   = 2'd1,
		ST_REFUSED = 2'd2,
		ST_NONE    = 2'd3
	} cvs_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_ACCESS,
		S_SCAN,
		S_FINISH
	} cvs_state_t;

	// controller -> datapath
	typedef struct packed {
		logic capture;
		logic scan_init;
		logic scan_run;
		logic finish;
	} cvs_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic need_scan;
		logic scan_done;
	} cvs_sts_t;

endpackage

// File: src/cvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
module cvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: src/cvs_ctrl.sv
// Control state machine of the victim selector: sequencing and output valid.
module cvs_ctrl
	import cvs_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	output logic       m_tvalid,
	input  logic       m_tready,
	output cvs_cmd_t   cmd,
	input  cvs_sts_t   sts
);

	cvs_state_t state_q, state_nxt;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign m_tvalid = out_valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q     <= state_nxt;
			out_valid_q <= cmd.finish || (out_valid_q && !m_tready);
		end
	end

	always_comb begin
		state_nxt = state_q;
		cmd       = '0;
		s_tready  = 1'b0;
		case (state_q)
			S_IDLE: begin
				s_tready = 1'b1;
				if (s_tvalid) begin
					cmd.capture = 1'b1;
					state_nxt   = S_ACCESS;
				end
			end
			S_ACCESS: begin
				if (sts.need_scan) begin
					cmd.scan_init = 1'b1;
					state_nxt     = S_SCAN;
				end else begin
					state_nxt = S_FINISH;
				end
			end
			S_SCAN: begin
				cmd.scan_run = 1'b1;
				if (sts.scan_done) begin
					state_nxt = S_FINISH;
				end
			end
			S_FINISH: begin
				if (out_free) begin
					cmd.finish = 1'b1;
					state_nxt  = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

`ifndef NO_ASSERTIONS
	a_finish_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> (!out_valid_q || m_tready))
		else $error("result written over an untaken result");
	a_finish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> m_tvalid)
		else $error("finished request left no result");
	a_one_at_a_time: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready) |=> !s_tready)
		else $error("second request taken while one is in work");
	a_scan_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN && !sts.scan_done) |=> (state_q == S_SCAN))
		else $error("scan left before the last entry");
`endif

endmodule

// File: src/cvs_datapath.sv
// Datapath: entry table, tiered victim scan, loaded count and result register.
module cvs_datapath
	import cvs_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cvs_cmd_t             cmd,
	output cvs_sts_t             sts,
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	localparam int IW   = $clog2(ENTRIES);
	localparam int CW   = $clog2(ENTRIES + 1);
	localparam int EW   = (IW > IDX_W) ? IW : IDX_W;
	localparam int KW   = (CW > COUNT_W) ? CW : COUNT_W;
	localparam int RW   = LEN_W + HIT_W;

	// request fields
	logic [OP_W-1:0]  op_q;
	logic [IDX_W-1:0] idx_q;
	logic [LEN_W-1:0] len_q;

	// configuration
	logic [MAXL_W-1:0] max_loaded_q;
	logic              static_q;

	// per-entry flags
	logic [ENTRIES-1:0] loaded_q;
	logic [ENTRIES-1:0] dirty_q;
	logic [ENTRIES-1:0] written_q;
	logic [CW-1:0]      count_q;

	// table RAM: {entry size, hit count}
	logic          ram_we;
	logic [IW-1:0] ram_waddr;
	logic [RW-1:0] ram_wdata;
	logic [IW-1:0] ram_raddr;
	logic [RW-1:0] ram_rdata;
	logic          rd_valid_s1;

	// scan
	logic [CW-1:0] scan_cnt_q;
	logic          scan_issue;
	logic          scan_vld_s1;
	logic [IW-1:0] scan_idx_s1;

	logic              f1_q, f2_q, f3_q;
	logic [HIT_W-1:0]  m1_q, m2_q, m3_q;
	logic [IW-1:0]     c1_q, c2_q, c3_q;
	logic              r2_q, r3_q, d3_q;

	// decode
	logic [EW:0]       idx_ext;
	logic              idx_ok;
	logic [IW-1:0]     idx_addr;
	logic              grow;
	logic [LEN_W-1:0]  cur_size;
	logic [HIT_W-1:0]  cur_hit;
	logic              sc_ld, sc_dt, sc_ge;
	logic              up1, up2, up3;

	// finish actions
	logic              fl_loaded_we, fl_loaded_val;
	logic              fl_dirty_we, fl_dirty_val;
	logic [IW-1:0]     fl_addr;
	logic [CW-1:0]     count_nxt;
	cvs_status_t       res_status;
	logic [IW-1:0]     res_vidx;
	logic              res_wb, res_reuse;
	logic [EW-1:0]     vidx_ext;
	logic [KW-1:0]     count_ext;
	logic [IW-1:0]     sel_idx;
	logic [HIT_W-1:0]  sel_hit;
	logic              sel_wb, sel_reuse;

	assign idx_ext  = (EW + 1)'(idx_q);
	assign idx_ok   = idx_ext < (EW + 1)'(ENTRIES);
	assign idx_addr = idx_ext[IW-1:0];
	assign grow     = KW'(count_q) < KW'(max_loaded_q);

	assign sts.need_scan = (op_q == OP_FIND) && !grow;
	assign sts.scan_done = (scan_cnt_q == CW'(ENTRIES)) && !scan_vld_s1;

	assign scan_issue = cmd.scan_run && (scan_cnt_q != CW'(ENTRIES));
	assign ram_raddr  = cmd.scan_run ? scan_cnt_q[IW-1:0] : idx_addr;

	// a never-written entry reads as zero
	assign cur_size = rd_valid_s1 ? ram_rdata[RW-1:HIT_W] : '0;
	assign cur_hit  = rd_valid_s1 ? ram_rdata[HIT_W-1:0]  : '0;

	cvs_ram #(
		.WIDTH(RW),
		.DEPTH(ENTRIES)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk) begin
		rd_valid_s1 <= written_q[ram_raddr];
		scan_idx_s1 <= scan_cnt_q[IW-1:0];
		if (cmd.capture) begin
			op_q  <= s_tdata[OP_W-1:0];
			idx_q <= s_tdata[OP_W +: IDX_W];
			len_q <= s_tdata[OP_W+IDX_W +: LEN_W];
		end
	end

	// scan compare stage, one entry per cycle
	assign sc_ld = loaded_q[scan_idx_s1];
	assign sc_dt = dirty_q[scan_idx_s1];
	assign sc_ge = cur_size >= len_q;
	assign up1   = scan_vld_s1 && sc_ld && !sc_dt && sc_ge && (cur_hit < m1_q);
	assign up2   = scan_vld_s1 && sc_ld && !sc_dt && (cur_hit < m2_q);
	assign up3   = scan_vld_s1 && sc_ld && (cur_hit < m3_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_cnt_q  <= '0;
			scan_vld_s1 <= 1'b0;
			f1_q        <= 1'b0;
			f2_q        <= 1'b0;
			f3_q        <= 1'b0;
		end else begin
			scan_vld_s1 <= scan_issue;
			if (cmd.scan_init) begin
				scan_cnt_q <= '0;
				f1_q       <= 1'b0;
				f2_q       <= 1'b0;
				f3_q       <= 1'b0;
			end else begin
				if (scan_issue) scan_cnt_q <= scan_cnt_q + CW'(1);
				if (up1) f1_q <= 1'b1;
				if (up2) f2_q <= 1'b1;
				if (up3) f3_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.scan_init) begin
			m1_q <= HIT_LIMIT;
			m2_q <= HIT_LIMIT;
			m3_q <= HIT_LIMIT;
		end else begin
			if (up1) begin
				m1_q <= cur_hit;
				c1_q <= scan_idx_s1;
			end
			if (up2) begin
				m2_q <= cur_hit;
				c2_q <= scan_idx_s1;
				r2_q <= sc_ge;
			end
			if (up3) begin
				m3_q <= cur_hit;
				c3_q <= scan_idx_s1;
				r3_q <= sc_ge;
				d3_q <= sc_dt;
			end
		end
	end

	// victim of the first tier that found one
	always_comb begin
		if (f1_q) begin
			sel_idx   = c1_q;
			sel_hit   = m1_q;
			sel_wb    = 1'b0;
			sel_reuse = 1'b1;
		end else if (f2_q) begin
			sel_idx   = c2_q;
			sel_hit   = m2_q;
			sel_wb    = 1'b0;
			sel_reuse = r2_q;
		end else begin
			sel_idx   = c3_q;
			sel_hit   = m3_q;
			sel_wb    = d3_q;
			sel_reuse = r3_q;
		end
	end

	always_comb begin
		ram_we        = 1'b0;
		ram_waddr     = idx_addr;
		ram_wdata     = {cur_size, cur_hit};
		fl_loaded_we  = 1'b0;
		fl_loaded_val = 1'b0;
		fl_dirty_we   = 1'b0;
		fl_dirty_val  = 1'b0;
		fl_addr       = idx_addr;
		count_nxt     = count_q;
		res_status    = ST_DONE;
		res_vidx      = '0;
		res_wb        = 1'b0;
		res_reuse     = 1'b0;
		case (op_q)
			OP_TOUCH: begin
				if (idx_ok) begin
					ram_we    = 1'b1;
					ram_wdata = {cur_size, (cur_hit < HIT_MAX) ? cur_hit + 8'd1 : cur_hit};
				end
			end
			OP_DIRTY: begin
				fl_dirty_we  = idx_ok;
				fl_dirty_val = 1'b1;
			end
			OP_CLEAN: begin
				fl_dirty_we = idx_ok;
			end
			OP_LOAD: begin
				if (idx_ok) begin
					ram_we        = 1'b1;
					ram_wdata     = {len_q, cur_hit};
					fl_loaded_we  = 1'b1;
					fl_loaded_val = 1'b1;
					fl_dirty_we   = 1'b1;
					count_nxt     = count_q + CW'(!loaded_q[idx_addr]);
				end
			end
			OP_RELEASE: begin
				if (idx_ok) begin
					ram_we       = 1'b1;
					ram_wdata    = {{LEN_W{1'b0}}, cur_hit};
					fl_loaded_we = 1'b1;
					fl_dirty_we  = 1'b1;
					count_nxt    = count_q - CW'(loaded_q[idx_addr]);
				end
			end
			OP_FIND: begin
				if (!grow) begin
					if (f1_q || f2_q || f3_q) begin
						res_vidx  = sel_idx;
						res_wb    = sel_wb;
						res_reuse = sel_reuse;
						if (static_q) begin
							res_status = ST_REFUSED;
						end else begin
							res_status   = ST_EVICT;
							ram_we       = 1'b1;
							ram_waddr    = sel_idx;
							ram_wdata    = {{LEN_W{1'b0}}, sel_hit};
							fl_addr      = sel_idx;
							fl_loaded_we = 1'b1;
							fl_dirty_we  = 1'b1;
							count_nxt    = count_q - CW'(1);
						end
					end else begin
						res_status = ST_NONE;
					end
				end
			end
			default: begin
				res_status = ST_DONE;
			end
		endcase
		if (!cmd.finish) begin
			ram_we       = 1'b0;
			fl_loaded_we = 1'b0;
			fl_dirty_we  = 1'b0;
		end
	end

	assign vidx_ext  = EW'(res_vidx);
	assign count_ext = KW'(count_nxt);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			loaded_q     <= '0;
			dirty_q      <= '0;
			written_q    <= '0;
			count_q      <= '0;
			max_loaded_q <= MAXL_RESET;
			static_q     <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					CFG_MAX_LOADED:  max_loaded_q <= cfg_wdata[MAXL_W-1:0];
					CFG_STATIC_MODE: static_q     <= cfg_wdata[0];
					default:         static_q     <= static_q;
				endcase
			end
			if (fl_loaded_we) loaded_q[fl_addr] <= fl_loaded_val;
			if (fl_dirty_we)  dirty_q[fl_addr]  <= fl_dirty_val;
			if (ram_we)       written_q[ram_waddr] <= 1'b1;
			if (cmd.finish)   count_q <= count_nxt;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			m_tdata <= {3'b000, count_ext[COUNT_W-1:0], res_reuse, res_wb,
				vidx_ext[IDX_W-1:0], res_status};
		end
	end

endmodule

// File: src/cache_victim_selector_core.sv
// Top level of the cache victim selector: controller, datapath and ports.
//
// Requests come in on the s_ channel (operation, entry index, length); each
// request gives exactly one response on the m_ channel. Operations: touch,
// mark dirty, mark clean, load, release, find victim. Find victim grows while
// fewer than max_loaded entries are loaded, else picks the least-hit clean
// entry that fits, then the least-hit clean one, then the least-hit of all
// (hit count below 100, lowest index on ties), and unloads it unless
// static_mode is set.
// Table updates and a find that grows need no scan; a find that scans reads
// the table RAM at one entry per cycle through its single read port.
// One request is in work at a time, so a new one is taken only once the last
// has finished; s_tready is high while the block idles, also when a response
// still waits in the output register. If the receiver stalls, a finished
// request waits until the output register is free.
// Reset clears all flags, counts and the loaded count; max_loaded returns to
// 16 and static_mode to 0. No clearing pass: entries never written read as 0.
// Configuration writes (cfg_we) take effect at once; the user must see that
// they are made while idle, as the block does not enforce it.
module cache_victim_selector_core
	import cvs_pkg::*;
#(
	parameter int ENTRIES = ENTRIES_DEFAULT
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// [2:0] operation, [6:3] entry_index, [22:7] length, [23] zero
	input  logic [S_TDATA_W-1:0] s_tdata,
	output logic                 m_tvalid,
	input  logic                 m_tready,
	// [1:0] status, [5:2] victim_index, [6] victim_writeback,
	// [7] victim_reusable, [12:8] loaded_count, [15:13] zero
	output logic [M_TDATA_W-1:0] m_tdata,
	input  logic                 cfg_we,
	input  logic                 cfg_index,
	input  logic [CFG_W-1:0]     cfg_wdata
);

	cvs_cmd_t cmd;
	cvs_sts_t sts;

	cvs_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.cmd     (cmd),
		.sts     (sts)
	);

	// table, scan and response register
	cvs_datapath #(
		.ENTRIES(ENTRIES)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tdata  (m_tdata),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata)
	);

endmodule
